// ===== sv/wua_pkg.sv =====
// Package for the wide unsigned integer ALU: opcodes, widths and defaults.
// No dependencies.
package wua_pkg;
  localparam int unsigned DefaultWidth = 96;
  localparam int unsigned WordW        = 32;
  localparam int unsigned IoW          = 96;
  localparam int unsigned OpW          = 3;
  localparam int unsigned ShW          = 7;

  typedef enum logic [OpW-1:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpCmp = 3'd2,
    OpShl = 3'd3,
    OpMul = 3'd4,
    OpDiv = 3'd5
  } op_e;

  // result beat payload
  typedef struct packed {
    logic              div_zero;
    logic [1:0]        order;
    logic              overflow_flag;
    logic [IoW-1:0]    rem;
    logic [IoW-1:0]    res;
  } result_t;
endpackage

// ===== sv/wua_core.sv =====
// Iterative datapath of the wide unsigned ALU: one shared adder/subtractor for add,
// subtract, compare, shift-add multiply and restoring divide; a small sequencer also runs the bit-wise shift.
// Depends on wua_pkg.
module wua_core #(
  parameter int unsigned Width = wua_pkg::DefaultWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [wua_pkg::OpW-1:0]  op_i,
  input  logic [Width-1:0]         a_i,
  input  logic [Width-1:0]         b_i,
  input  logic [wua_pkg::ShW-1:0]  sh_i,
  input  logic                     ready_i,
  output logic                     done_o,
  output wua_pkg::result_t         result_o
);
  localparam int unsigned CntW = $clog2(Width + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [wua_pkg::OpW-1:0] op_q;
  logic [Width-1:0]  a_q, a_d, b_q, b_d, r_q, r_d, q_q, q_d;
  logic              ovf_q, ovf_d;
  logic [1:0]        ord_q, ord_d;
  logic              dz_q, dz_d;

  // shared unit: Width+1 bit add or subtract
  logic              sub_sel;
  logic [Width-1:0]  alu_x, alu_y;
  logic [Width:0]    alu_s;
  always_comb begin
    alu_s = sub_sel ? ({1'b0, alu_x} - {1'b0, alu_y}) : ({1'b0, alu_x} + {1'b0, alu_y});
  end

  // partial remainder shifted left with the next dividend bit
  logic [Width-1:0] rem_sh;
  logic [Width:0]   rem_wide;
  assign rem_wide = {q_q, a_q[Width-1]};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d = a_q; b_d = b_q; r_d = r_q; q_d = q_q;
    ovf_d = ovf_q; ord_d = ord_q; dz_d = dz_q;
    sub_sel = 1'b0;
    alu_x   = r_q;
    alu_y   = b_q;
    rem_sh  = '0;
    done_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          a_d = a_i; b_d = b_i; r_d = '0; q_d = '0;
          ovf_d = 1'b0; ord_d = 2'd0; dz_d = 1'b0;
          cnt_d = CntW'(Width);
          if (op_i == wua_pkg::OpShl) begin
            if ({{(32-wua_pkg::ShW){1'b0}}, sh_i} >= Width) begin
              cnt_d = '0;
              ovf_d = |a_i;
            end else begin
              cnt_d = CntW'(sh_i);
            end
          end
          if (op_i == wua_pkg::OpDiv && b_i == '0) begin
            dz_d = 1'b1;
            cnt_d = '0;
          end
          state_d = StRun;
        end
      end
      StRun: begin
        case (op_q)
          wua_pkg::OpAdd: begin
            alu_x = a_q;
            r_d   = alu_s[Width-1:0];
            ovf_d = alu_s[Width];
            state_d = StDone;
          end
          wua_pkg::OpSub, wua_pkg::OpCmp: begin
            alu_x = a_q;
            sub_sel = 1'b1;
            if (op_q == wua_pkg::OpSub) begin
              r_d   = alu_s[Width-1:0];
              ovf_d = alu_s[Width];
            end else begin
              ord_d = alu_s[Width] ? 2'b11 : ((alu_s[Width-1:0] != '0) ? 2'b01 : 2'b00);
            end
            state_d = StDone;
          end
          wua_pkg::OpShl: begin
            // one bit per cycle; a set top bit leaving flags overflow
            if (cnt_q == '0 || ovf_q) begin
              r_d = ovf_q ? '0 : a_q;
              state_d = StDone;
            end else begin
              if (a_q[Width-1]) ovf_d = 1'b1;
              a_d   = a_q << 1;
              cnt_d = cnt_q - 1'b1;
            end
          end
          wua_pkg::OpMul: begin
            // MSB-first shift-add: r = 2r + a*b_bit
            if (cnt_q == '0) begin
              state_d = StDone;
            end else begin
              if (r_q[Width-1]) ovf_d = 1'b1;
              alu_x = r_q << 1;
              alu_y = b_q[Width-1] ? a_q : '0;
              r_d   = alu_s[Width-1:0];
              if (alu_s[Width]) ovf_d = 1'b1;
              b_d   = b_q << 1;
              cnt_d = cnt_q - 1'b1;
            end
          end
          wua_pkg::OpDiv: begin
            // restoring divide through the shared subtractor, one quotient bit per cycle
            if (cnt_q == '0) begin
              state_d = StDone;
            end else begin
              rem_sh  = rem_wide[Width-1:0];
              alu_x   = rem_sh;
              sub_sel = 1'b1;
              if (rem_wide[Width] || !alu_s[Width]) begin
                q_d = alu_s[Width-1:0];
                r_d = {r_q[Width-2:0], 1'b1};
              end else begin
                q_d = rem_sh;
                r_d = {r_q[Width-2:0], 1'b0};
              end
              a_d   = a_q << 1;
              cnt_d = cnt_q - 1'b1;
            end
          end
          default: state_d = StDone;
        endcase
      end
      StDone: begin
        // hold the result until the output register can take it
        done_o = 1'b1;
        if (ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) op_q <= op_i;
    a_q <= a_d; b_q <= b_d; r_q <= r_d; q_q <= q_d;
    ovf_q <= ovf_d; ord_q <= ord_d; dz_q <= dz_d;
  end

  // widen or trim to the 96-bit port view
  always_comb begin
    result_o.res = '0;
    result_o.rem = '0;
    for (int i = 0; i < wua_pkg::IoW; i++) begin
      if (i < Width) begin
        result_o.res[i] = r_q[i];
        result_o.rem[i] = (op_q == wua_pkg::OpDiv) ? q_q[i] : 1'b0;
      end
    end
    result_o.overflow_flag = ovf_q;
    result_o.order         = ord_q;
    result_o.div_zero      = dz_q;
  end
endmodule

// ===== sv/wide_unsigned_integer_alu_unit.sv =====
// Top level of the wide unsigned integer ALU: stream ports and output register.
// Depends on wua_pkg and wua_core.
//
// One operation at a time. Add, subtract and compare make a single pass through
// the shared adder; shift left moves one bit per cycle up to shift_amount bits,
// ending early once a set bit leaves the top, and it skips the loop for a shift
// distance of Width or more; multiply and divide loop over all Width bits, one
// bit per cycle through the shared adder. A zero divisor skips the loop. The
// result sits in an output register, and the next beat is taken while it waits;
// a finished result that finds that register still full holds the core, and so
// the input, until the register drains.
module wide_unsigned_integer_alu_unit #(
  parameter int unsigned Width = wua_pkg::DefaultWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], a_word0..2 [98:3], b_word0..2 [194:99], shift_amount [201:195]
  input  logic [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_word0..2 [95:0], rem_word0..2 [191:96], overflow_flag [192], order [194:193],
  // div_zero [195]
  output logic [199:0] m_axis_tdata
);
  logic             busy_q;
  logic             start, done;
  logic [Width-1:0] a, b;
  wua_pkg::result_t res;
  logic             ov_q;
  logic             out_free;
  wua_pkg::result_t out_q;

  assign s_axis_tready = !busy_q;
  assign start = s_axis_tvalid && s_axis_tready;
  // output register empty, or its beat leaves this cycle
  assign out_free = !ov_q || m_axis_tready;

  always_comb begin
    a = '0;
    b = '0;
    for (int i = 0; i < Width; i++) begin
      if (i < wua_pkg::IoW) begin
        a[i] = s_axis_tdata[3 + i];
        b[i] = s_axis_tdata[99 + i];
      end
    end
  end

  wua_core #(.Width(Width)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (s_axis_tdata[2:0]),
    .a_i      (a),
    .b_i      (b),
    .sh_i     (s_axis_tdata[201:195]),
    .ready_i  (out_free),
    .done_o   (done),
    .result_o (res)
  );

  // busy from accept until the result moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (start) busy_q <= 1'b1;
      else if (done && out_free) busy_q <= 1'b0;
      if (done && out_free) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) out_q <= res;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, out_q};
endmodule
